// File: hw/rtl/ssp_pkg.sv
// ----------------------------------------------------------------------------
// String splitter package
// Shared record, job and configuration types, register indexes and sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package ssp_pkg;

   localparam int UNIT_W  = 16;
   localparam int COUNT_W = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int QUEUE_DEPTH = 4;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_SEPARATOR_A    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEPARATOR_B    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEPARATOR_C    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEPARATOR_D    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEPARATORS_USE = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_PART_LIMIT     = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_DROP_EMPTY     = 3'd6;

   localparam logic [COUNT_W-1:0] PART_LIMIT_RESET = 16'hFFFF;

   // Record kinds.
   localparam logic KIND_PART = 1'b0;
   localparam logic KIND_END  = 1'b1;

   typedef struct packed {
      logic [2:0]         active_count;
      logic [COUNT_W-1:0] part_limit;
      logic               drop_empty;
   } cfg_type;

   typedef struct packed {
      logic               record_kind;
      logic [COUNT_W-1:0] part_start;
      logic [COUNT_W-1:0] part_length;
      logic [COUNT_W-1:0] parts_total;
      logic               final_record;
   } rec_type;

   // Up to three records caused by one item, in output order:
   // separator part, tail part, end record.
   localparam int JOB_SEP  = 0;
   localparam int JOB_TAIL = 1;
   localparam int JOB_END  = 2;

   typedef struct packed {
      logic [2:0] mask;
      rec_type    end_rec;
      rec_type    tail_rec;
      rec_type    sep_rec;
   } job_type;

endpackage

`default_nettype wire

// File: hw/rtl/ssp_stream_if.sv
// ----------------------------------------------------------------------------
// String splitter stream interfaces
// Valid/ready channels for code units in and part records out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssp_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_unit;
   logic        unit_present;
   logic        string_end;

   modport source (output valid, code_unit, unit_present, string_end, input ready);
   modport sink   (input valid, code_unit, unit_present, string_end, output ready);
endinterface

interface ssp_rsp_if;
   logic        valid;
   logic        ready;
   logic        record_kind;
   logic [15:0] part_start;
   logic [15:0] part_length;
   logic [15:0] parts_total;
   logic        final_record;

   modport source (output valid, record_kind, part_start, part_length, parts_total,
                   final_record, input ready);
   modport sink   (input valid, record_kind, part_start, part_length, parts_total,
                   final_record, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/ssp_front.sv
// ----------------------------------------------------------------------------
// String splitter front end
// Takes one code unit per cycle unless the job queue is full, tracks the
// string state and builds the records the unit causes as one queue job.
// ----------------------------------------------------------------------------
`default_nettype none

module ssp_front #(
   parameter int MAX_STRING_LENGTH = 65535,
   parameter int SEPARATOR_SLOTS   = 4
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire ssp_pkg::cfg_type    cfg,
   input  wire logic [15:0]         separators [SEPARATOR_SLOTS],
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire logic [15:0]         in_code_unit,
   input  wire logic                in_unit_present,
   input  wire logic                in_string_end,
   input  wire logic                queue_full,
   output logic                     push,
   output ssp_pkg::job_type         push_job
);

   localparam logic [15:0] MAX_LEN   = 16'(MAX_STRING_LENGTH);
   localparam logic [2:0]  SLOTS     = 3'(SEPARATOR_SLOTS);

   logic [15:0] unit_position_ff, unit_position_in;
   logic [15:0] part_begin_ff, part_begin_in;
   logic [15:0] parts_found_ff, parts_found_in;
   logic        limit_reached_ff, limit_reached_in;

   logic        accept;
   logic        take;
   logic        hit;
   logic [2:0]  active;
   logic        is_sep;
   logic [15:0] sep_len;
   logic        emit_sep;
   logic [15:0] found_sep;
   logic        reached_sep;
   logic [15:0] begin_sep;
   logic [15:0] total_len;
   logic        emit_tail;
   logic [15:0] tail_start;
   logic [15:0] found_tail;

   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;

   always_comb begin
      active = (cfg.active_count > SLOTS) ? SLOTS : cfg.active_count;
      hit = 1'b0;
      for (int i = 0; i < SEPARATOR_SLOTS; i++) begin
         if ((3'(i) < active) && (separators[i] == in_code_unit)) begin
            hit = 1'b1;
         end
      end
   end

   always_comb begin
      take    = in_unit_present && (unit_position_ff < MAX_LEN);
      is_sep  = take && (cfg.part_limit >= 16'd2) && !limit_reached_ff && hit;
      sep_len = unit_position_ff - part_begin_ff;
      emit_sep  = is_sep && (!cfg.drop_empty || (sep_len != 16'd0));
      found_sep = emit_sep ? parts_found_ff + 16'd1 : parts_found_ff;
      reached_sep = limit_reached_ff ||
                    (emit_sep && (found_sep == cfg.part_limit - 16'd1));
      begin_sep = is_sep ? unit_position_ff + 16'd1 : part_begin_ff;
      total_len = take ? unit_position_ff + 16'd1 : unit_position_ff;

      // The tail is the part after the last separator, or the whole string
      // when the limit is one.
      if (cfg.part_limit == 16'd1) begin
         emit_tail  = !(cfg.drop_empty && (total_len == 16'd0));
         tail_start = 16'd0;
         found_tail = emit_tail ? 16'd1 : found_sep;
      end else if (cfg.part_limit >= 16'd2) begin
         emit_tail  = reached_sep || (begin_sep < total_len);
         tail_start = begin_sep;
         found_tail = emit_tail ? found_sep + 16'd1 : found_sep;
      end else begin
         emit_tail  = 1'b0;
         tail_start = begin_sep;
         found_tail = found_sep;
      end
   end

   always_comb begin
      push_job = '0;
      push_job.mask[ssp_pkg::JOB_SEP]  = emit_sep;
      push_job.mask[ssp_pkg::JOB_TAIL] = in_string_end && emit_tail;
      push_job.mask[ssp_pkg::JOB_END]  = in_string_end;

      push_job.sep_rec.record_kind  = ssp_pkg::KIND_PART;
      push_job.sep_rec.part_start   = part_begin_ff;
      push_job.sep_rec.part_length  = sep_len;
      push_job.sep_rec.parts_total  = found_sep;
      push_job.sep_rec.final_record = 1'b0;

      push_job.tail_rec.record_kind  = ssp_pkg::KIND_PART;
      push_job.tail_rec.part_start   = tail_start;
      push_job.tail_rec.part_length  = total_len - tail_start;
      push_job.tail_rec.parts_total  = found_tail;
      push_job.tail_rec.final_record = 1'b0;

      push_job.end_rec.record_kind  = ssp_pkg::KIND_END;
      push_job.end_rec.part_start   = 16'd0;
      push_job.end_rec.part_length  = total_len;
      push_job.end_rec.parts_total  = found_tail;
      push_job.end_rec.final_record = 1'b1;

      push = accept && (emit_sep || in_string_end);
   end

   always_comb begin
      unit_position_in = unit_position_ff;
      part_begin_in    = part_begin_ff;
      parts_found_in   = parts_found_ff;
      limit_reached_in = limit_reached_ff;
      if (accept) begin
         if (in_string_end) begin
            unit_position_in = '0;
            part_begin_in    = '0;
            parts_found_in   = '0;
            limit_reached_in = 1'b0;
         end else begin
            unit_position_in = total_len;
            part_begin_in    = begin_sep;
            parts_found_in   = found_sep;
            limit_reached_in = reached_sep;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_position_ff <= '0;
         part_begin_ff    <= '0;
         parts_found_ff   <= '0;
         limit_reached_ff <= 1'b0;
      end else begin
         unit_position_ff <= unit_position_in;
         part_begin_ff    <= part_begin_in;
         parts_found_ff   <= parts_found_in;
         limit_reached_ff <= limit_reached_in;
      end
   end

   // A part never starts past the units counted so far.
   assert property (@(posedge clock) disable iff (reset)
      part_begin_ff <= unit_position_ff || limit_reached_ff)
      else $error("part start ran past the unit count");

   // Every job pushed at a string end carries the end record.
   assert property (@(posedge clock) disable iff (reset)
      (accept && in_string_end) |-> (push && push_job.mask[ssp_pkg::JOB_END]))
      else $error("string end produced no end record");

   // State is cleared in the cycle after an accepted string end.
   assert property (@(posedge clock) disable iff (reset)
      (accept && in_string_end) |=> (unit_position_ff == 16'd0 && !limit_reached_ff))
      else $error("string state not cleared after string end");

endmodule

`default_nettype wire

// File: hw/rtl/ssp_queue.sv
// ----------------------------------------------------------------------------
// String splitter job queue
// Short first-in first-out buffer of record jobs between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ssp_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire ssp_pkg::job_type  push_job,
   output logic                   full,
   input  wire logic              pop,
   output logic                   head_valid,
   output ssp_pkg::job_type       head_job
);

   localparam int PTR_W = $clog2(ssp_pkg::QUEUE_DEPTH);
   localparam int CNT_W = PTR_W + 1;

   ssp_pkg::job_type slot_ff [ssp_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_W'(ssp_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("push into a full job queue");

   assert property (@(posedge clock) disable iff (reset) pop |-> head_valid)
      else $error("pop from an empty job queue");

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(ssp_pkg::QUEUE_DEPTH))
      else $error("job queue count out of range");

endmodule

`default_nettype wire

// File: hw/rtl/ssp_back.sv
// ----------------------------------------------------------------------------
// String splitter back end
// Unpacks each job into its records and sends them out one per cycle while
// the receiver is ready, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ssp_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              head_valid,
   input  wire ssp_pkg::job_type  head_job,
   output logic                   pop,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output ssp_pkg::rec_type       out_rec
);

   ssp_pkg::job_type job_ff, job_in;
   logic [2:0]       pend_ff, pend_in;
   logic             out_valid_ff, out_valid_in;
   ssp_pkg::rec_type out_rec_ff, out_rec_in;

   logic             out_free;
   logic             emit;
   logic [2:0]       pick;
   logic [2:0]       pend_after;
   ssp_pkg::rec_type pick_rec;

   always_comb begin
      out_free = !out_valid_ff || out_ready;
      emit     = out_free && (pend_ff != 3'b000);

      // Records leave in order: separator part, tail part, end record.
      if (pend_ff[ssp_pkg::JOB_SEP]) begin
         pick     = 3'b001;
         pick_rec = job_ff.sep_rec;
      end else if (pend_ff[ssp_pkg::JOB_TAIL]) begin
         pick     = 3'b010;
         pick_rec = job_ff.tail_rec;
      end else begin
         pick     = 3'b100;
         pick_rec = job_ff.end_rec;
      end

      pend_after = emit ? (pend_ff & ~pick) : pend_ff;
      pop        = (pend_after == 3'b000) && head_valid;
      pend_in    = pop ? head_job.mask : pend_after;
      job_in     = pop ? head_job : job_ff;

      if (emit) begin
         out_valid_in = 1'b1;
         out_rec_in   = pick_rec;
      end else begin
         out_valid_in = out_ready ? 1'b0 : out_valid_ff;
         out_rec_in   = out_rec_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff     <= job_in;
      out_rec_ff <= out_rec_in;
   end

   assign out_valid = out_valid_ff;
   assign out_rec   = out_rec_ff;

   // A job loaded from the queue always carries at least one record.
   assert property (@(posedge clock) disable iff (reset)
      pop |-> (head_job.mask != 3'b000))
      else $error("empty job in queue");

   // A new job is loaded only once the current one is fully sent.
   assert property (@(posedge clock) disable iff (reset)
      pop |-> (pend_after == 3'b000))
      else $error("job loaded over pending records");

   // A record waiting at the output is not replaced before its transfer.
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ready) |=> (out_valid_ff && $stable(out_rec_ff)))
      else $error("output record changed while stalled");

endmodule

`default_nettype wire

// File: hw/rtl/string_splitter.sv
// Path: each job is written into the job queue, loaded into the back end job
//    register, and its records leave through the registered output stage.
// Throughput: one item per cycle while each item causes at most one record and
//    the receiver is ready; records leave at one per cycle, and a string end causes
//    up to three records. A four-entry job queue absorbs such bursts.
// Reset: configuration returns to its reset values, string state and queue clear.
// ----------------------------------------------------------------------------
// String splitter top level
// Splits a code unit stream on configured separators into part records.
// ----------------------------------------------------------------------------
`default_nettype none

module string_splitter #(
   parameter int MAX_STRING_LENGTH = 65535,
   parameter int SEPARATOR_SLOTS   = 4
) (
   input  wire logic          clock,
   input  wire logic          reset,
   ssp_req_if.sink            req_bus,
   ssp_rsp_if.source          rsp_bus,
   input  wire logic          csr_we,
   input  wire logic [2:0]    csr_index,
   input  wire logic [15:0]   csr_wdata
);

   logic [15:0]      separator_ff [SEPARATOR_SLOTS];
   ssp_pkg::cfg_type cfg_ff;

   logic             queue_full;
   logic             push;
   ssp_pkg::job_type push_job;
   logic             pop;
   logic             head_valid;
   ssp_pkg::job_type head_job;
   ssp_pkg::rec_type out_rec;

   // Separator slots beyond the configured count are never compared, so
   // only the slots that exist get storage.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SEPARATOR_SLOTS; i++) begin
            separator_ff[i] <= '0;
         end
         cfg_ff.active_count <= '0;
         cfg_ff.part_limit   <= ssp_pkg::PART_LIMIT_RESET;
         cfg_ff.drop_empty   <= 1'b0;
      end else if (csr_we) begin
         for (int i = 0; i < SEPARATOR_SLOTS; i++) begin
            if (csr_index == 3'(i)) begin
               separator_ff[i] <= csr_wdata;
            end
         end
         unique case (csr_index)
            ssp_pkg::CSR_SEPARATORS_USE: cfg_ff.active_count <= csr_wdata[2:0];
            ssp_pkg::CSR_PART_LIMIT:     cfg_ff.part_limit   <= csr_wdata;
            ssp_pkg::CSR_DROP_EMPTY:     cfg_ff.drop_empty   <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   ssp_front #(
      .MAX_STRING_LENGTH (MAX_STRING_LENGTH),
      .SEPARATOR_SLOTS   (SEPARATOR_SLOTS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .separators      (separator_ff),
      .in_valid        (req_bus.valid),
      .in_ready        (req_bus.ready),
      .in_code_unit    (req_bus.code_unit),
      .in_unit_present (req_bus.unit_present),
      .in_string_end   (req_bus.string_end),
      .queue_full      (queue_full),
      .push            (push),
      .push_job        (push_job)
   );

   ssp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   ssp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .out_valid  (rsp_bus.valid),
      .out_ready  (rsp_bus.ready),
      .out_rec    (out_rec)
   );

   assign rsp_bus.record_kind  = out_rec.record_kind;
   assign rsp_bus.part_start   = out_rec.part_start;
   assign rsp_bus.part_length  = out_rec.part_length;
   assign rsp_bus.parts_total  = out_rec.parts_total;
   assign rsp_bus.final_record = out_rec.final_record;

endmodule

`default_nettype wire

// File: test/part_record_check.sv
// ----------------------------------------------------------------------------
// String splitter record checker
// Watches the configuration port and both channels, predicts the part and
// end records for every accepted code unit, and compares them in order.
// ----------------------------------------------------------------------------
module part_record_check (
   input  logic        clock,
   input  logic        reset,
   ssp_req_if          req_mon,
   ssp_rsp_if          rsp_mon,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          failures,
   output int          outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [15:0] LONGEST_STRING = 16'hFFFF;

   // Shadow of the configuration registers.
   logic [15:0] sep_value [4];
   logic [2:0]  sep_active;
   logic [15:0] limit_cfg;
   logic        drop_cfg;

   // Per-string state.
   logic [15:0] pos_count;
   logic [15:0] begin_index;
   logic [15:0] parts_count;
   logic        limit_hit;

   ssp_pkg::rec_type expected_records [$];

   function automatic void push_record(input logic kind, input logic [15:0] start,
                                       input logic [15:0] length,
                                       input logic [15:0] total, input logic last);
      ssp_pkg::rec_type rec;
      rec.record_kind  = kind;
      rec.part_start   = start;
      rec.part_length  = length;
      rec.parts_total  = total;
      rec.final_record = last;
      expected_records.push_back(rec);
   endfunction

   task automatic split_unit(input logic [15:0] unit, input logic present,
                             input logic at_end);
      logic        match;
      int          active;
      int          k;
      logic [15:0] total_len;
      match  = 1'b0;
      active = (sep_active > 3'd4) ? 4 : int'(sep_active);
      for (k = 0; k < active; k++) begin
         if (sep_value[k] == unit) match = 1'b1;
      end
      // Units past the longest string are neither counted nor compared.
      if (present && pos_count < LONGEST_STRING) begin
         if (limit_cfg >= 16'd2 && !limit_hit && match) begin
            if (!drop_cfg || pos_count != begin_index) begin
               parts_count = parts_count + 16'd1;
               push_record(ssp_pkg::KIND_PART, begin_index, pos_count - begin_index,
                           parts_count, 1'b0);
               if (parts_count == limit_cfg - 16'd1) limit_hit = 1'b1;
            end
            begin_index = pos_count + 16'd1;
         end
         pos_count = pos_count + 16'd1;
      end
      if (at_end) begin
         total_len = pos_count;
         if (limit_cfg == 16'd1) begin
            if (!(drop_cfg && total_len == 16'd0)) begin
               parts_count = 16'd1;
               push_record(ssp_pkg::KIND_PART, 16'd0, total_len, parts_count, 1'b0);
            end
         end else if (limit_cfg >= 16'd2) begin
            // Once the limit is reached the rest is a part even when empty.
            if (limit_hit || begin_index < total_len) begin
               parts_count = parts_count + 16'd1;
               push_record(ssp_pkg::KIND_PART, begin_index, total_len - begin_index,
                           parts_count, 1'b0);
            end
         end
         push_record(ssp_pkg::KIND_END, 16'd0, total_len, parts_count, 1'b1);
         pos_count   = '0;
         begin_index = '0;
         parts_count = '0;
         limit_hit   = 1'b0;
      end
   endtask

   function automatic void compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      ssp_pkg::rec_type want;
      if (reset) begin
         foreach (sep_value[k]) sep_value[k] = '0;
         sep_active  = '0;
         limit_cfg   = ssp_pkg::PART_LIMIT_RESET;
         drop_cfg    = 1'b0;
         pos_count   = '0;
         begin_index = '0;
         parts_count = '0;
         limit_hit   = 1'b0;
         failures    = 0;
         expected_records.delete();
      end else begin
         if (csr_we) begin
            case (csr_index) inside
               ssp_pkg::CSR_SEPARATOR_A, ssp_pkg::CSR_SEPARATOR_B,
               ssp_pkg::CSR_SEPARATOR_C, ssp_pkg::CSR_SEPARATOR_D: begin
                  sep_value[csr_index[1:0]] = csr_wdata;
               end
               ssp_pkg::CSR_SEPARATORS_USE: sep_active = csr_wdata[2:0];
               ssp_pkg::CSR_PART_LIMIT:     limit_cfg  = csr_wdata;
               ssp_pkg::CSR_DROP_EMPTY:     drop_cfg   = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            split_unit(req_mon.code_unit, req_mon.unit_present, req_mon.string_end);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_records.size() == 0) begin
               $error("unexpected record: kind %0d start %0d length %0d total %0d final %0d",
                      rsp_mon.record_kind, rsp_mon.part_start, rsp_mon.part_length,
                      rsp_mon.parts_total, rsp_mon.final_record);
               failures++;
            end else begin
               want = expected_records.pop_front();
               compare_field("record_kind", want.record_kind, rsp_mon.record_kind);
               compare_field("part_start", want.part_start, rsp_mon.part_start);
               compare_field("part_length", want.part_length, rsp_mon.part_length);
               compare_field("parts_total", want.parts_total, rsp_mon.parts_total);
               compare_field("final_record", want.final_record, rsp_mon.final_record);
            end
         end
      end
      outstanding = expected_records.size();
   end

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// String splitter testbench
// Drives directed and random strings under several separator, limit and
// drop settings with bursty input and a stalling receiver; the record checker
// beside the block predicts and compares every record.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum {RX_OPEN, RX_COIN, RX_THIRD, RX_MOSTLY, RX_HOLD} rx_mode_type;

   localparam logic [15:0] COMMA = 16'h002C;
   localparam logic [15:0] SEMI  = 16'h003B;
   localparam int PHASE_ITEMS    = 40;
   localparam int SQUEEZE_CYCLES = 80;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;
   int          failures;
   int          outstanding;

   logic [15:0] cfg_sep [4];
   int          burst_left = 0;
   int          stream_items = 0;
   logic        squeeze_req = 1'b0;
   logic        squeeze_done = 1'b0;

   ssp_req_if req_bus ();
   ssp_rsp_if rsp_bus ();

   string_splitter dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   part_record_check record_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .failures    (failures),
      .outstanding (outstanding)
   );

   always #5 clock = ~clock;

   initial begin
      #8_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // Sends one item in bursts of random length; returns after its transfer.
   task automatic send_item(input logic [15:0] unit, input logic present, input logic last);
      if (burst_left == 0) begin
         repeat ($urandom_range(1, 4)) begin
            @(negedge clock);
            req_bus.valid <= 1'b0;
         end
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 8);
      end
      burst_left--;
      @(negedge clock);
      req_bus.valid        <= 1'b1;
      req_bus.code_unit    <= unit;
      req_bus.unit_present <= present;
      req_bus.string_end   <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (present || last) stream_items++;
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [15:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic apply_config(input logic [15:0] a, input logic [15:0] b,
                               input logic [15:0] c, input logic [15:0] d,
                               input logic [2:0] in_use, input logic [15:0] limit,
                               input logic drop);
      wait_drained();
      csr_write(ssp_pkg::CSR_SEPARATOR_A, a);
      csr_write(ssp_pkg::CSR_SEPARATOR_B, b);
      csr_write(ssp_pkg::CSR_SEPARATOR_C, c);
      csr_write(ssp_pkg::CSR_SEPARATOR_D, d);
      csr_write(ssp_pkg::CSR_SEPARATORS_USE, {13'd0, in_use});
      csr_write(ssp_pkg::CSR_PART_LIMIT, limit);
      csr_write(ssp_pkg::CSR_DROP_EMPTY, {15'd0, drop});
      @(negedge clock);
      csr_we <= 1'b0;
      cfg_sep[0] = a;
      cfg_sep[1] = b;
      cfg_sep[2] = c;
      cfg_sep[3] = d;
   endtask

   // Separators are favored so that most strings split into several parts.
   function automatic logic [15:0] pick_unit();
      int r;
      r = $urandom_range(0, 99);
      if (r < 35) return cfg_sep[$urandom_range(0, 3)];
      else if (r < 50) return 16'($urandom);
      else return 16'h0061 + 16'($urandom_range(0, 3));
   endfunction

   task automatic send_string(input int len);
      int k;
      if (len == 0) begin
         send_item(16'($urandom), 1'b0, 1'b1);
      end else begin
         for (k = 0; k < len; k++) begin
            if ($urandom_range(0, 19) == 0) send_item(16'($urandom), 1'b0, 1'b0);
            if (k == len - 1 && $urandom_range(0, 9) == 0) begin
               // The string may also end on an item that carries no unit.
               send_item(pick_unit(), 1'b1, 1'b0);
               send_item(16'($urandom), 1'b0, 1'b1);
            end else begin
               send_item(pick_unit(), 1'b1, k == len - 1);
            end
         end
      end
   endtask

   task automatic run_phase();
      int start;
      start = stream_items;
      while (stream_items - start < PHASE_ITEMS) begin
         send_string(($urandom_range(0, 9) == 0) ? $urandom_range(11, 30)
                                                 : $urandom_range(0, 8));
      end
   endtask

   initial begin : receiver
      rx_mode_type rx_mode;
      int          span;
      int          k;
      rsp_bus.ready = 1'b0;
      forever begin
         if (squeeze_req && !squeeze_done) begin
            squeeze_done = 1'b1;
            repeat (SQUEEZE_CYCLES) begin
               @(negedge clock);
               rsp_bus.ready <= 1'b0;
            end
         end
         rx_mode = rx_mode_type'($urandom_range(0, 4));
         span    = $urandom_range(8, 48);
         for (k = 0; k < span; k++) begin
            @(negedge clock);
            case (rx_mode)
               RX_OPEN:   rsp_bus.ready <= 1'b1;
               RX_COIN:   rsp_bus.ready <= 1'($urandom_range(0, 1));
               RX_THIRD:  rsp_bus.ready <= (k % 3) == 0;
               RX_MOSTLY: rsp_bus.ready <= (k % 8) != 7;
               default:   rsp_bus.ready <= (k > span - 4);
            endcase
         end
      end
   end

   initial begin : stimulus
      logic [15:0] sep_r;
      reset                = 1'b1;
      csr_we               = 1'b0;
      csr_index            = '0;
      csr_wdata            = '0;
      req_bus.valid        = 1'b0;
      req_bus.code_unit    = '0;
      req_bus.unit_present = 1'b0;
      req_bus.string_end   = 1'b0;
      foreach (cfg_sep[i]) cfg_sep[i] = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: an empty string, then a string with no active separator.
      send_item(16'h0000, 1'b0, 1'b1);
      send_item(16'h0061, 1'b1, 1'b0);
      send_item(16'h0062, 1'b1, 1'b1);

      // Extreme separator values, a repeated separator, an empty part, an item
      // without a unit in mid-string, and a trailing separator.
      apply_config(COMMA, 16'h0000, 16'hFFFF, COMMA, 3'd4, 16'hFFFF, 1'b0);
      send_item(16'h0041, 1'b1, 1'b0);
      send_item(COMMA, 1'b1, 1'b0);
      send_item(COMMA, 1'b1, 1'b0);
      send_item(16'hFFFF, 1'b1, 1'b0);
      send_item(16'h0000, 1'b1, 1'b0);
      send_item(16'h1234, 1'b0, 1'b0);
      send_item(16'h8000, 1'b1, 1'b1);
      send_item(16'h0062, 1'b1, 1'b0);
      send_item(COMMA, 1'b1, 1'b1);

      // A limit of one: the empty string gives a zero-length part.
      apply_config(COMMA, 16'h0000, 16'hFFFF, COMMA, 3'd4, 16'd1, 1'b0);
      send_item(16'h0000, 1'b0, 1'b1);
      send_item(16'h0061, 1'b1, 1'b0);
      send_item(COMMA, 1'b1, 1'b0);
      send_item(16'h0062, 1'b1, 1'b1);

      // A limit of zero gives no parts at all.
      apply_config(COMMA, 16'h0000, 16'hFFFF, COMMA, 3'd4, 16'd0, 1'b0);
      send_item(16'h0061, 1'b1, 1'b0);
      send_item(COMMA, 1'b1, 1'b0);
      send_item(16'h0062, 1'b1, 1'b1);

      // Oversized separator count, dropped empty part, separators after the limit.
      apply_config(COMMA, SEMI, 16'h0000, 16'h0000, 3'd7, 16'd2, 1'b1);
      send_item(COMMA, 1'b1, 1'b0);
      send_item(16'h0061, 1'b1, 1'b0);
      send_item(SEMI, 1'b1, 1'b0);
      send_item(16'h0062, 1'b1, 1'b0);
      send_item(COMMA, 1'b1, 1'b0);
      send_item(16'h0063, 1'b1, 1'b1);

      // With empty parts dropped, the empty string gives no part under limit one, only the end record.
      apply_config(COMMA, SEMI, 16'h0000, 16'h0000, 3'd7, 16'd1, 1'b1);
      send_item(16'h0000, 1'b0, 1'b1);

      // Random phases; the first one also holds the receiver off for a long
      // stretch while input keeps coming.
      apply_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   3'd4, 16'hFFFF, 1'b0);
      squeeze_req = 1'b1;
      run_phase();

      apply_config(16'h0000, 16'hFFFF, 16'($urandom), 16'($urandom), 3'd2, 16'd3, 1'b1);
      run_phase();

      sep_r = 16'($urandom);
      apply_config(sep_r, sep_r, 16'($urandom), 16'($urandom), 3'd7, 16'd2, 1'b0);
      run_phase();

      apply_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   3'd1, 16'd1, 1'b1);
      run_phase();

      apply_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   3'($urandom_range(0, 7)), 16'($urandom_range(0, 5)),
                   1'($urandom_range(0, 1)));
      run_phase();

      apply_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   3'd3, 16'd0, 1'($urandom_range(0, 1)));
      run_phase();

      apply_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   3'd5, 16'd4, 1'b0);
      run_phase();

      wait_drained();
      repeat (8) @(negedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// File: files.f
hw/rtl/ssp_pkg.sv
hw/rtl/ssp_stream_if.sv
hw/rtl/ssp_front.sv
hw/rtl/ssp_queue.sv
hw/rtl/ssp_back.sv
hw/rtl/string_splitter.sv
test/part_record_check.sv
test/testbench.sv
